// File: sv/jts_pkg.sv
// Shared types for the JSON token scanner: item structs, token kinds, op codes.
// Used by json_token_scanner; depends on nothing else.
`timescale 1ns / 1ps

package jts_pkg;

  // Width of the byte offset counter and of the offset and length fields
  localparam int POS_BITS = 20;

  // Op codes of an input item
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [3:0] {
    TK_COMMA   = 4'd0,
    TK_COLON   = 4'd1,
    TK_LBRACK  = 4'd2,
    TK_RBRACK  = 4'd3,
    TK_LBRACE  = 4'd4,
    TK_RBRACE  = 4'd5,
    TK_STRING  = 4'd6,
    TK_INT     = 4'd7,
    TK_FLOAT   = 4'd8,
    TK_BOOL    = 4'd9,
    TK_NULL    = 4'd10,
    TK_UNKNOWN = 4'd11,
    TK_END     = 4'd12
  } token_kind_t;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } text_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    pos_t        token_start;
    pos_t        token_length;
    logic        run_last;
  } token_item_t;

endpackage

// File: sv/json_token_scanner.sv
// Top level of the JSON token scanner: byte classifier, scan state and token queue.
// Depends on jts_pkg for the item structs and token kinds.
`timescale 1ns / 1ps

// JSON token scanner. Feed a document one byte per item on the text channel
// (op = byte) and close it with an end item; tokens come out on the token
// channel with kind, start offset and length, and run_last marks the last
// token caused by one input item (an item may cause zero, one or two tokens).
// Every item is scanned in the cycle it is accepted, so the block takes one
// item per clock; results pass through a four-entry token queue, and text is
// stalled only when that queue has fewer than two free entries, i.e. when the
// token side stalls for long. After an error one UNKNOWN token is emitted and
// the rest of the document is dropped until the end item, which always gives
// END and rearms the scanner for the next document. Offsets saturate at the
// top of the offset counter.
module json_token_scanner (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  jts_pkg::text_item_t text,
  output logic                token_valid,
  input  logic                token_stall,
  output jts_pkg::token_item_t token
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam jts_pkg::pos_t POS_MAX = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_MINUS, M_ZERO, M_INTD, M_DOT, M_FRAC, M_EXP,
    M_EXPSIGN, M_EXPD, M_LTRUE, M_LFALSE, M_LNULL, M_DBOOL, M_DNULL
  } mode_t;

  // Outcome of scanning one byte between tokens
  typedef struct packed {
    mode_t                mode;
    logic [2:0]           lit;
    logic                 emit;
    logic                 fail;
    jts_pkg::token_kind_t kind;
  } idle_scan_t;

  // Character classes
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == 8'h65) || (c == 8'h45);
  endfunction

  // Expected byte of a literal at a given index
  function automatic logic [7:0] lit_char(input mode_t m, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (m)
      M_LTRUE: begin
        case (idx)
          3'd1: ch = 8'h72;    // r
          3'd2: ch = 8'h75;    // u
          3'd3: ch = 8'h65;    // e
          default: ch = 8'h00;
        endcase
      end
      M_LFALSE: begin
        case (idx)
          3'd1: ch = 8'h61;    // a
          3'd2: ch = 8'h6c;    // l
          3'd3: ch = 8'h73;    // s
          3'd4: ch = 8'h65;    // e
          default: ch = 8'h00;
        endcase
      end
      M_LNULL: begin
        case (idx)
          3'd1: ch = 8'h75;    // u
          3'd2: ch = 8'h6c;    // l
          3'd3: ch = 8'h6c;    // l
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Index of the last byte of a literal
  function automatic logic [2:0] lit_last(input mode_t m);
    return (m == M_LFALSE) ? 3'd4 : 3'd3;
  endfunction

  // Classify a byte that arrives between tokens
  function automatic idle_scan_t scan_idle(input logic [7:0] c);
    idle_scan_t r;
    r.mode = M_IDLE;
    r.lit  = 3'd0;
    r.emit = 1'b0;
    r.fail = 1'b0;
    r.kind = jts_pkg::TK_UNKNOWN;
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: r.emit = 1'b0;
      CH_COMMA: begin r.emit = 1'b1; r.kind = jts_pkg::TK_COMMA; end
      CH_COLON: begin r.emit = 1'b1; r.kind = jts_pkg::TK_COLON; end
      CH_LBRK:  begin r.emit = 1'b1; r.kind = jts_pkg::TK_LBRACK; end
      CH_RBRK:  begin r.emit = 1'b1; r.kind = jts_pkg::TK_RBRACK; end
      CH_LBRC:  begin r.emit = 1'b1; r.kind = jts_pkg::TK_LBRACE; end
      CH_RBRC:  begin r.emit = 1'b1; r.kind = jts_pkg::TK_RBRACE; end
      CH_QUOTE: r.mode = M_STR;
      CH_MINUS: r.mode = M_MINUS;
      CH_ZERO:  r.mode = M_ZERO;
      8'h74:    begin r.mode = M_LTRUE;  r.lit = 3'd1; end   // t
      8'h66:    begin r.mode = M_LFALSE; r.lit = 3'd1; end   // f
      8'h6e:    begin r.mode = M_LNULL;  r.lit = 3'd1; end   // n
      default: begin
        if (is_digit(c)) begin
          r.mode = M_INTD;
        end else begin
          r.emit = 1'b1;
          r.fail = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Scan state
  mode_t         mode, mode_next;
  logic          esc, esc_next;
  logic [2:0]    hex_left, hex_left_next;
  logic [2:0]    lit, lit_next;
  jts_pkg::pos_t pos, pos_next;
  jts_pkg::pos_t start, start_next;
  logic          err, err_next;

  // Token queue
  jts_pkg::token_item_t qmem [QDEPTH];
  logic [QPTR_W-1:0]    rd_ptr, wr_ptr;
  logic [QCNT_W-1:0]    count;

  logic                 accept, pop;
  logic [7:0]           c;
  jts_pkg::pos_t        pos_inc, len1;
  idle_scan_t           ir;
  logic                 fail, close, rescan;
  jts_pkg::token_kind_t close_kind;
  logic                 emit_a, emit_b;
  jts_pkg::token_item_t item_a, item_b;
  jts_pkg::token_item_t res0, res1;
  logic [1:0]           n_res;

  assign accept      = text_valid && !text_stall;
  assign pop         = token_valid && !token_stall;
  assign text_stall  = count > QCNT_W'(QDEPTH - 2);
  assign token_valid = count != '0;
  assign token       = qmem[rd_ptr];

  assign c       = text.text_byte;
  assign pos_inc = (pos == POS_MAX) ? pos : pos + 1'b1;
  assign len1    = pos_inc - pos;
  assign ir      = scan_idle(c);

  // Scan one item: next state and up to two tokens
  always_comb begin
    mode_next     = mode;
    esc_next      = esc;
    hex_left_next = hex_left;
    lit_next      = lit;
    pos_next      = pos;
    start_next    = start;
    err_next      = err;
    fail          = 1'b0;
    close         = 1'b0;
    rescan        = 1'b0;
    close_kind    = jts_pkg::TK_INT;
    emit_a        = 1'b0;
    emit_b        = 1'b0;
    item_a        = '{token_kind: jts_pkg::TK_UNKNOWN, token_start: start,
                      token_length: '0, run_last: 1'b0};
    item_b        = '{token_kind: ir.kind, token_start: pos,
                      token_length: ir.fail ? '0 : len1, run_last: 1'b0};

    if (accept && (text.op == jts_pkg::OP_BYTE)) begin
      pos_next = pos_inc;
      if (!err) begin
        case (mode)
          M_STR: begin
            if ((c == CH_TAB) || (c == CH_CR) || (c == CH_LF)) begin
              fail = 1'b1;
            end else if (hex_left != 3'd0) begin
              if (is_hex(c)) hex_left_next = hex_left - 3'd1;
              else fail = 1'b1;
            end else if (esc) begin
              if ((c == CH_QUOTE) || (c == CH_BSL) || (c == CH_SLASH) ||
                  (c == 8'h62) || (c == 8'h66) || (c == 8'h6e) ||
                  (c == 8'h72) || (c == 8'h74) || (c == 8'h75)) begin
                if (c == 8'h75) hex_left_next = 3'd4;
                esc_next = 1'b0;
              end else begin
                fail = 1'b1;
              end
            end else if (c == CH_BSL) begin
              esc_next = 1'b1;
            end else if (c == CH_QUOTE) begin
              // closing quote is part of the string
              emit_a = 1'b1;
              item_a.token_kind   = jts_pkg::TK_STRING;
              item_a.token_length = pos_inc - start;
              mode_next = M_IDLE;
            end
          end
          M_MINUS: begin
            if (c == CH_ZERO) mode_next = M_ZERO;
            else if (is_digit(c)) mode_next = M_INTD;
            else fail = 1'b1;
          end
          M_ZERO: begin
            if (c == CH_DOT) mode_next = M_DOT;
            else if (is_exp(c)) mode_next = M_EXP;
            else if (is_digit(c)) fail = 1'b1;
            else begin close = 1'b1; close_kind = jts_pkg::TK_INT; end
          end
          M_INTD: begin
            if (is_digit(c)) mode_next = M_INTD;
            else if (c == CH_DOT) mode_next = M_DOT;
            else if (is_exp(c)) mode_next = M_EXP;
            else begin close = 1'b1; close_kind = jts_pkg::TK_INT; end
          end
          M_DOT: begin
            if (is_digit(c)) mode_next = M_FRAC;
            else fail = 1'b1;
          end
          M_FRAC: begin
            if (is_digit(c)) mode_next = M_FRAC;
            else if (is_exp(c)) mode_next = M_EXP;
            else if (c == CH_DOT) fail = 1'b1;
            else begin close = 1'b1; close_kind = jts_pkg::TK_FLOAT; end
          end
          M_EXP: begin
            if (is_digit(c)) mode_next = M_EXPD;
            else if ((c == CH_PLUS) || (c == CH_MINUS)) mode_next = M_EXPSIGN;
            else fail = 1'b1;
          end
          M_EXPSIGN: begin
            if (is_digit(c)) mode_next = M_EXPD;
            else fail = 1'b1;
          end
          M_EXPD: begin
            if (is_digit(c)) mode_next = M_EXPD;
            else if ((c == CH_DOT) || is_exp(c)) fail = 1'b1;
            else begin close = 1'b1; close_kind = jts_pkg::TK_FLOAT; end
          end
          M_LTRUE, M_LFALSE, M_LNULL: begin
            if (c == lit_char(mode, lit)) begin
              lit_next = lit + 3'd1;
              if (lit == lit_last(mode)) mode_next = (mode == M_LNULL) ? M_DNULL : M_DBOOL;
            end else begin
              fail = 1'b1;
            end
          end
          M_DBOOL: begin close = 1'b1; close_kind = jts_pkg::TK_BOOL; end
          M_DNULL: begin close = 1'b1; close_kind = jts_pkg::TK_NULL; end
          default: rescan = 1'b1;
        endcase

        // Drop the rest of the document after a failed token
        if (fail) begin
          emit_a    = 1'b1;
          err_next  = 1'b1;
          mode_next = M_IDLE;
        end

        // Close a number or literal, then scan this byte from idle
        if (close) begin
          emit_a              = 1'b1;
          item_a.token_kind   = close_kind;
          item_a.token_length = pos - start;
          rescan              = 1'b1;
        end

        if (rescan) begin
          start_next    = pos;
          mode_next     = ir.mode;
          emit_b        = ir.emit;
          if (ir.mode == M_STR) begin
            esc_next      = 1'b0;
            hex_left_next = 3'd0;
          end
          if (ir.lit != 3'd0) lit_next = ir.lit;
          if (ir.fail) err_next = 1'b1;
        end
      end
    end else if (accept) begin
      // End of document: close any pending token, emit END, rearm
      if (!err) begin
        emit_a = 1'b1;
        item_a.token_length = pos - start;
        case (mode)
          M_IDLE:          emit_a = 1'b0;
          M_ZERO, M_INTD:  item_a.token_kind = jts_pkg::TK_INT;
          M_FRAC, M_EXPD:  item_a.token_kind = jts_pkg::TK_FLOAT;
          M_DBOOL:         item_a.token_kind = jts_pkg::TK_BOOL;
          M_DNULL:         item_a.token_kind = jts_pkg::TK_NULL;
          default:         item_a.token_length = '0;
        endcase
      end
      emit_b = 1'b1;
      item_b = '{token_kind: jts_pkg::TK_END, token_start: pos,
                 token_length: '0, run_last: 1'b0};
      mode_next     = M_IDLE;
      esc_next      = 1'b0;
      hex_left_next = 3'd0;
      lit_next      = 3'd0;
      pos_next      = '0;
      start_next    = '0;
      err_next      = 1'b0;
    end

    // Pack the tokens in order and mark the last one
    res0 = emit_a ? item_a : item_b;
    res1 = item_b;
    n_res = {1'b0, emit_a} + {1'b0, emit_b};
    res0.run_last = (n_res == 2'd1);
    res1.run_last = 1'b1;
  end

  // Hold scan state and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      esc      <= 1'b0;
      hex_left <= 3'd0;
      lit      <= 3'd0;
      pos      <= '0;
      start    <= '0;
      err      <= 1'b0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      count    <= '0;
    end else begin
      mode     <= mode_next;
      esc      <= esc_next;
      hex_left <= hex_left_next;
      lit      <= lit_next;
      pos      <= pos_next;
      start    <= start_next;
      err      <= err_next;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (accept) wr_ptr <= wr_ptr + QPTR_W'(n_res);
      count <= count + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
    end
  end

  // Write tokens into the queue
  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) qmem[wr_ptr] <= res0;
    if (accept && (n_res == 2'd2)) qmem[wr_ptr + 1'b1] <= res1;
  end

endmodule

// File: sim/json_token_scanner_tb.sv
// Self-checking testbench for json_token_scanner: drives directed and random JSON text,
// predicts every token in a small scoreboard class and compares the output field by field.
// Depends on jts_pkg and json_token_scanner.
`timescale 1ns / 1ps

module json_token_scanner_tb;

  // Scanner state as the scoreboard tracks it
  typedef enum logic [4:0] {
    SM_IDLE, SM_STR, SM_MINUS, SM_ZERO, SM_INT, SM_DOT, SM_FRAC, SM_EXP, SM_EXP_SIGN,
    SM_EXP_DIGITS, SM_TRUE, SM_FALSE, SM_NULL, SM_BOOL_DONE, SM_NULL_DONE
  } scan_mode_e;

  localparam int RX_HOLD_CYCLES  = 300;
  // Longest legal quiet stretch is the receiver hold-off; leave a wide margin
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int TAIL_CYCLES     = 16;

  class token_scoreboard;
    jts_pkg::token_item_t due_tokens[$];
    int                   errors;
    scan_mode_e           mode;
    bit                   esc_pending;
    bit                   dropping;
    int                   hex_left;
    int                   lit_idx;
    jts_pkg::pos_t        byte_pos;
    jts_pkg::pos_t        tok_start;

    function new();
      errors = 0;
      clear_doc();
    endfunction

    function void clear_doc();
      mode        = SM_IDLE;
      esc_pending = 1'b0;
      dropping    = 1'b0;
      hex_left    = 0;
      lit_idx     = 0;
      byte_pos    = '0;
      tok_start   = '0;
    endfunction

    function int pending();
      return due_tokens.size();
    endfunction

    // Advance an offset, holding at the top of the counter
    function jts_pkg::pos_t next_pos(jts_pkg::pos_t p);
      return (p == '1) ? p : p + 1'b1;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function void emit(jts_pkg::token_kind_t k, jts_pkg::pos_t s, jts_pkg::pos_t l);
      jts_pkg::token_item_t t;
      t.token_kind   = k;
      t.token_start  = s;
      t.token_length = l;
      t.run_last     = 1'b0;
      due_tokens.push_back(t);
    endfunction

    // Report the failed token and drop the rest of the document
    function void fail(jts_pkg::pos_t s);
      emit(jts_pkg::TK_UNKNOWN, s, '0);
      dropping = 1'b1;
      mode     = SM_IDLE;
    endfunction

    function void scan_idle(logic [7:0] c, jts_pkg::pos_t cur);
      jts_pkg::pos_t one;
      one       = next_pos(cur) - cur;
      tok_start = cur;
      case (c)
        " ", 8'h09, 8'h0A, 8'h0D: ;
        ",": emit(jts_pkg::TK_COMMA, cur, one);
        ":": emit(jts_pkg::TK_COLON, cur, one);
        "[": emit(jts_pkg::TK_LBRACK, cur, one);
        "]": emit(jts_pkg::TK_RBRACK, cur, one);
        "{": emit(jts_pkg::TK_LBRACE, cur, one);
        "}": emit(jts_pkg::TK_RBRACE, cur, one);
        "\"": begin
          mode        = SM_STR;
          esc_pending = 1'b0;
          hex_left    = 0;
        end
        "-": mode = SM_MINUS;
        "0": mode = SM_ZERO;
        "t": begin
          mode    = SM_TRUE;
          lit_idx = 1;
        end
        "f": begin
          mode    = SM_FALSE;
          lit_idx = 1;
        end
        "n": begin
          mode    = SM_NULL;
          lit_idx = 1;
        end
        default: begin
          if (is_digit(c)) mode = SM_INT;
          else fail(cur);
        end
      endcase
    endfunction

    // Close a number or literal at this byte, then scan the byte itself
    function void close_rescan(jts_pkg::token_kind_t k, logic [7:0] c, jts_pkg::pos_t cur);
      emit(k, tok_start, cur - tok_start);
      mode = SM_IDLE;
      scan_idle(c, cur);
    endfunction

    function void match_lit(string word, scan_mode_e done, logic [7:0] c);
      if (lit_idx < word.len() && c == word[lit_idx]) begin
        lit_idx++;
        if (lit_idx == word.len()) mode = done;
      end else begin
        fail(tok_start);
      end
    endfunction

    function void scan_byte(logic [7:0] c, jts_pkg::pos_t cur);
      bit numlike;
      bit expch;
      expch   = (c == "e" || c == "E");
      numlike = is_digit(c) || c == "." || expch;
      case (mode)
        SM_STR: begin
          if (c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
            fail(tok_start);
          end else if (hex_left != 0) begin
            if (is_hex(c)) hex_left--;
            else fail(tok_start);
          end else if (esc_pending) begin
            case (c)
              "\"", "\\", "/", "b", "f", "n", "r", "t": esc_pending = 1'b0;
              "u": begin
                esc_pending = 1'b0;
                hex_left    = 4;
              end
              default: fail(tok_start);
            endcase
          end else if (c == "\\") begin
            esc_pending = 1'b1;
          end else if (c == "\"") begin
            emit(jts_pkg::TK_STRING, tok_start, next_pos(cur) - tok_start);
            mode = SM_IDLE;
          end
        end
        SM_MINUS: begin
          if (c == "0") mode = SM_ZERO;
          else if (is_digit(c)) mode = SM_INT;
          else fail(tok_start);
        end
        SM_ZERO: begin
          if (c == ".") mode = SM_DOT;
          else if (expch) mode = SM_EXP;
          else if (numlike) fail(tok_start);
          else close_rescan(jts_pkg::TK_INT, c, cur);
        end
        SM_INT: begin
          if (c == ".") mode = SM_DOT;
          else if (expch) mode = SM_EXP;
          else if (!is_digit(c)) close_rescan(jts_pkg::TK_INT, c, cur);
        end
        SM_DOT: begin
          if (is_digit(c)) mode = SM_FRAC;
          else fail(tok_start);
        end
        SM_FRAC: begin
          if (expch) mode = SM_EXP;
          else if (is_digit(c)) ;
          else if (numlike) fail(tok_start);
          else close_rescan(jts_pkg::TK_FLOAT, c, cur);
        end
        SM_EXP: begin
          if (is_digit(c)) mode = SM_EXP_DIGITS;
          else if (c == "+" || c == "-") mode = SM_EXP_SIGN;
          else fail(tok_start);
        end
        SM_EXP_SIGN: begin
          if (is_digit(c)) mode = SM_EXP_DIGITS;
          else fail(tok_start);
        end
        SM_EXP_DIGITS: begin
          if (is_digit(c)) ;
          else if (numlike) fail(tok_start);
          else close_rescan(jts_pkg::TK_FLOAT, c, cur);
        end
        SM_TRUE:      match_lit("true", SM_BOOL_DONE, c);
        SM_FALSE:     match_lit("false", SM_BOOL_DONE, c);
        SM_NULL:      match_lit("null", SM_NULL_DONE, c);
        SM_BOOL_DONE: close_rescan(jts_pkg::TK_BOOL, c, cur);
        SM_NULL_DONE: close_rescan(jts_pkg::TK_NULL, c, cur);
        default: begin
          mode = SM_IDLE;
          scan_idle(c, cur);
        end
      endcase
    endfunction

    // Predict the tokens caused by one accepted text item
    function void note_text(jts_pkg::text_item_t it);
      jts_pkg::pos_t        cur;
      int                   n_prior;
      jts_pkg::token_item_t t;
      cur     = byte_pos;
      n_prior = due_tokens.size();
      if (it.op == jts_pkg::OP_BYTE) begin
        if (!dropping) scan_byte(it.text_byte, cur);
        byte_pos = next_pos(cur);
      end else begin
        if (!dropping) begin
          case (mode)
            SM_IDLE: ;
            SM_ZERO, SM_INT:        emit(jts_pkg::TK_INT, tok_start, cur - tok_start);
            SM_FRAC, SM_EXP_DIGITS: emit(jts_pkg::TK_FLOAT, tok_start, cur - tok_start);
            SM_BOOL_DONE:           emit(jts_pkg::TK_BOOL, tok_start, cur - tok_start);
            SM_NULL_DONE:           emit(jts_pkg::TK_NULL, tok_start, cur - tok_start);
            default:                emit(jts_pkg::TK_UNKNOWN, tok_start, '0);
          endcase
        end
        emit(jts_pkg::TK_END, cur, '0);
        clear_doc();
      end
      // Mark the last token of this item
      if (due_tokens.size() > n_prior) begin
        t          = due_tokens.pop_back();
        t.run_last = 1'b1;
        due_tokens.push_back(t);
      end
    endfunction

    function void check_token(jts_pkg::token_item_t got);
      jts_pkg::token_item_t want;
      if (due_tokens.size() == 0) begin
        $display("%0t: token with no item waiting: kind %0d start %0d length %0d last %0b",
                 $time, got.token_kind, got.token_start, got.token_length, got.run_last);
        errors++;
        return;
      end
      want = due_tokens.pop_front();
      if (got.token_kind !== want.token_kind) begin
        $display("%0t: token_kind expected %0d, actual %0d",
                 $time, want.token_kind, got.token_kind);
        errors++;
      end
      if (got.token_start !== want.token_start) begin
        $display("%0t: token_start expected %0d, actual %0d",
                 $time, want.token_start, got.token_start);
        errors++;
      end
      if (got.token_length !== want.token_length) begin
        $display("%0t: token_length expected %0d, actual %0d",
                 $time, want.token_length, got.token_length);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last expected %0b, actual %0b",
                 $time, want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 text_valid = 1'b0;
  logic                 text_stall;
  jts_pkg::text_item_t  text = '0;
  logic                 token_valid;
  logic                 token_stall = 1'b0;
  jts_pkg::token_item_t token;

  token_scoreboard sb;
  logic [7:0]      doc_bytes[$];
  int              items_sent = 0;
  int              tx_gap_pct = 0;
  int              rx_stall_pct = 0;
  int              tx_calm_left = 0;
  int              rx_calm_left = 0;
  int              rx_hold_left = 0;
  int              rx_hold_reqs = 0;
  int              rx_hold_seen = 0;
  int              stuck_cycles = 0;

  json_token_scanner i_dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Token side: random stalls, calm stretches, and a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      token_stall <= 1'b1;
    end else if (rx_calm_left > 0) begin
      rx_calm_left--;
      token_stall <= 1'b0;
    end else begin
      if ($urandom_range(127) == 0) rx_calm_left = $urandom_range(80, 20);
      token_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Note accepted items before checking tokens; stop the run if nothing moves
  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && !text_stall) sb.note_text(text);
      if (token_valid && !token_stall) sb.check_token(token);
      if ((text_valid && !text_stall) || (token_valid && !token_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_CYCLES) begin
        $display("json_token_scanner: mismatch");
        $finish;
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_text(input logic op, input logic [7:0] b);
    jts_pkg::text_item_t t;
    t.op        = op;
    t.text_byte = b;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
    end else begin
      if ($urandom_range(63) == 0) tx_calm_left = $urandom_range(80, 20);
      while ($urandom_range(99) < tx_gap_pct) begin
        text_valid <= 1'b0;
        @(posedge clk);
      end
    end
    text_valid <= 1'b1;
    text       <= t;
    @(posedge clk);
    while (text_stall) @(posedge clk);
  endtask

  task automatic send_doc(input logic [7:0] end_byte);
    foreach (doc_bytes[i]) send_text(jts_pkg::OP_BYTE, doc_bytes[i]);
    send_text(jts_pkg::OP_END, end_byte);
    items_sent += doc_bytes.size() + 1;
    doc_bytes.delete();
  endtask

  // Pause the text side until every predicted token has come out
  task automatic drain_tokens();
    text_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  function automatic void put_digit(int lo);
    logic [7:0] c;
    c = 8'("0" + $urandom_range(9, lo));
    doc_bytes.push_back(c);
  endfunction

  function automatic void put_ws();
    repeat ($urandom_range(2)) begin
      case ($urandom_range(3))
        0:       doc_bytes.push_back(" ");
        1:       doc_bytes.push_back(8'h09);
        2:       doc_bytes.push_back(8'h0A);
        default: doc_bytes.push_back(8'h0D);
      endcase
    end
  endfunction

  function automatic void put_number();
    if ($urandom_range(3) == 0) doc_bytes.push_back("-");
    if ($urandom_range(2) == 0) begin
      doc_bytes.push_back("0");
    end else begin
      put_digit(1);
      repeat ($urandom_range(3)) put_digit(0);
    end
    if ($urandom_range(2) == 0) begin
      doc_bytes.push_back(".");
      repeat ($urandom_range(3, 1)) put_digit(0);
    end
    if ($urandom_range(3) == 0) begin
      doc_bytes.push_back($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: doc_bytes.push_back("+");
        1: doc_bytes.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(2, 1)) put_digit(0);
    end
  endfunction

  // String with plain, high, control, escaped and \u content
  function automatic void put_string();
    logic [7:0] c;
    doc_bytes.push_back("\"");
    repeat ($urandom_range(6)) begin
      case ($urandom_range(5))
        0, 1: begin
          c = 8'($urandom_range(126, 32));
          if (c == "\"" || c == "\\") c = "a";
          doc_bytes.push_back(c);
        end
        2: doc_bytes.push_back(8'($urandom_range(255, 128)));
        3: begin
          c = 8'($urandom_range(31));
          if (c == 8'h09 || c == 8'h0A || c == 8'h0D) c = 8'h1F;
          doc_bytes.push_back(c);
        end
        4: begin
          doc_bytes.push_back("\\");
          case ($urandom_range(7))
            0:       doc_bytes.push_back("\"");
            1:       doc_bytes.push_back("\\");
            2:       doc_bytes.push_back("/");
            3:       doc_bytes.push_back("b");
            4:       doc_bytes.push_back("f");
            5:       doc_bytes.push_back("n");
            6:       doc_bytes.push_back("r");
            default: doc_bytes.push_back("t");
          endcase
        end
        default: begin
          push_text("\\u");
          repeat (4) begin
            case ($urandom_range(2))
              0:       put_digit(0);
              1:       doc_bytes.push_back(8'("a" + $urandom_range(5)));
              default: doc_bytes.push_back(8'("A" + $urandom_range(5)));
            endcase
          end
        end
      endcase
    end
    doc_bytes.push_back("\"");
  endfunction

  function automatic void put_value(int depth);
    int n;
    n = $urandom_range(3);
    case ($urandom_range(depth > 0 ? 5 : 3))
      0: put_number();
      1: put_string();
      2: begin
        if ($urandom_range(1) != 0) push_text("true");
        else push_text("false");
      end
      3: push_text("null");
      4: begin
        doc_bytes.push_back("[");
        for (int i = 0; i < n; i++) begin
          if (i != 0) doc_bytes.push_back(",");
          put_ws();
          put_value(depth - 1);
          put_ws();
        end
        doc_bytes.push_back("]");
      end
      default: begin
        doc_bytes.push_back("{");
        for (int i = 0; i < n; i++) begin
          if (i != 0) doc_bytes.push_back(",");
          put_ws();
          put_string();
          put_ws();
          doc_bytes.push_back(":");
          put_ws();
          put_value(depth - 1);
        end
        doc_bytes.push_back("}");
      end
    endcase
  endfunction

  // Damage a well-formed document: overwrite, insert a troublesome or random byte, cut short
  function automatic void break_doc();
    int         at;
    logic [7:0] c;
    if (doc_bytes.size() == 0) doc_bytes.push_back(8'($urandom_range(255)));
    at = $urandom_range(doc_bytes.size() - 1);
    case ($urandom_range(3))
      0: doc_bytes[at] = 8'($urandom_range(255));
      1: begin
        case ($urandom_range(11))
          0:       c = ".";
          1:       c = "e";
          2:       c = "E";
          3:       c = "0";
          4:       c = "+";
          5:       c = "-";
          6:       c = 8'h09;
          7:       c = 8'h0A;
          8:       c = 8'h0D;
          9:       c = "\\";
          10:      c = "x";
          default: c = "\"";
        endcase
        doc_bytes.insert(at, c);
      end
      2: while (doc_bytes.size() > at + 1) doc_bytes.delete(doc_bytes.size() - 1);
      default: doc_bytes.insert($urandom_range(doc_bytes.size()), 8'($urandom_range(255)));
    endcase
  endfunction

  function automatic void random_doc();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(12, 1)) doc_bytes.push_back(8'($urandom_range(255)));
    end else begin
      put_ws();
      repeat ($urandom_range(3, 1)) begin
        put_value(2);
        put_ws();
      end
      if (pick < 40) break_doc();
    end
  endfunction

  task automatic random_phase(input int gap_pct, input int stall_pct, input int count);
    int first;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    first        = items_sent;
    while (items_sent - first < count) begin
      random_doc();
      send_doc(8'($urandom_range(255)));
      if ($urandom_range(15) == 0) drain_tokens();
    end
    drain_tokens();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes in a string, number closed by punctuation,
    // literal followed by a letter, stray byte
    tx_gap_pct   = 16;
    rx_stall_pct = 72;
    doc_bytes.push_back("\"");
    doc_bytes.push_back(8'h00);
    doc_bytes.push_back(8'hFF);
    push_text("\",");
    send_doc(8'hFF);
    push_text("-0.5e+7}");
    send_doc(8'h00);
    push_text("nullx");
    send_doc(8'($urandom_range(255)));
    doc_bytes.push_back(8'hFF);
    send_doc(8'($urandom_range(255)));
    drain_tokens();

    random_phase(16, 72, 630);

    // Hold the token side off while a burst of punctuation fills the block
    rx_hold_reqs++;
    doc_bytes.push_back("[");
    repeat (30) doc_bytes.push_back(",");
    doc_bytes.push_back("]");
    send_doc(8'($urandom_range(255)));
    drain_tokens();

    random_phase(72, 16, 630);
    random_phase(0, 0, 630);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("json_token_scanner: match");
    end else begin
      $display("json_token_scanner: mismatch");
    end
    $finish;
  end

endmodule

// File: json_token_scanner.f
sv/jts_pkg.sv
sv/json_token_scanner.sv
sim/json_token_scanner_tb.sv
